// ===== design/qcvc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcvc_pkg
// shared types and constants for the quantile center value clustering core
// ----------------------------------------------------------------------------
package qcvc_pkg;

	localparam int K_BITS       = 7;   // width of the cluster count register
	localparam int TAG_BITS     = 6;
	localparam int LABEL_BITS   = 6;
	localparam int OUT_VAL_BITS = 16;  // width of the value ports
	localparam int MAX_CLUSTERS = 64;
	localparam int CENTER_AW    = 6;

	localparam logic [K_BITS-1:0] K_RESET = 7'd20;
	localparam logic [K_BITS-1:0] K_MAX   = 7'd64;

	// control into the nearest center tracker
	typedef struct packed {
		logic clear;  // start a new item
		logic valid;  // a center is presented this cycle
	} near_ctl_t;

endpackage

// ===== design/quantile_center_value_clustering_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantile_center_value_clustering_core
// one dimensional k-means style labeling with centers at evenly spaced
// sorted positions
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+-----------
//  input    | in_valid in_ready item_value item_tag    | in
//           | last_item                                |
//  output   | out_valid out_ready out_tag out_value    | out
//           | cluster_label last_result                |
//  config   | cfg_valid cfg_ready cfg_data             | in
//
// an input item is inserted into a sorted ram as it arrives: each stored
// entry with a larger value is read and shifted up one place to open the hole
// the last item then runs the divider (a kick, then repeated subtraction of
// k from n), the center pick and for each result a pass through the nearest
// center search, where the single center ram read port sets the pace of one
// center per cycle
// reset clears only control state; the rams need no clearing pass
// a stalled output holds its result while the next result is computed; the
// sequencer waits only when a second result is ready before the first leaves
// ----------------------------------------------------------------------------
module quantile_center_value_clustering_core #(
	parameter int MAX_ITEMS  = 64,
	parameter int VALUE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input transactions
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [qcvc_pkg::OUT_VAL_BITS-1:0] item_value,
	input  logic [qcvc_pkg::TAG_BITS-1:0]   item_tag,
	input  logic                            last_item,
	// result transactions
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [qcvc_pkg::TAG_BITS-1:0]   out_tag,
	output logic [qcvc_pkg::OUT_VAL_BITS-1:0] out_value,
	output logic [qcvc_pkg::LABEL_BITS-1:0] cluster_label,
	output logic                            last_result,
	// cluster count register write
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qcvc_pkg::K_BITS-1:0]     cfg_data
);
	import qcvc_pkg::*;

	// stored value width: values are kept to their low SW bits (VALUE_BITS, at most OUT_VAL_BITS)
	localparam int SW = (VALUE_BITS < OUT_VAL_BITS) ? VALUE_BITS : OUT_VAL_BITS;
	localparam int EW = SW + TAG_BITS;             // sorted ram entry {value, tag}
	localparam int FW = $clog2(MAX_ITEMS + 1);     // fill count width
	localparam int AW = $clog2(MAX_ITEMS);         // sorted ram address width

	// sequencer states
	localparam logic [3:0] S_IDLE  = 4'd0;   // waiting for an item
	localparam logic [3:0] S_INS   = 4'd1;   // read the entry below the hole
	localparam logic [3:0] S_CMP   = 4'd2;   // shift it up or drop the item in
	localparam logic [3:0] S_DIV   = 4'd3;   // kick the divider
	localparam logic [3:0] S_DIVW  = 4'd4;   // wait for n / k
	localparam logic [3:0] S_CEN   = 4'd5;   // read the sorted value of a center
	localparam logic [3:0] S_CENW  = 4'd6;   // write it to the center ram
	localparam logic [3:0] S_LRD   = 4'd7;   // read the next sorted item
	localparam logic [3:0] S_LCAP  = 4'd8;   // capture it, clear the search
	localparam logic [3:0] S_SCAN  = 4'd9;   // stream centers through the search
	localparam logic [3:0] S_DRAIN = 4'd10;  // last center compare
	localparam logic [3:0] S_EMIT  = 4'd11;  // hand the result to the output reg

	logic [3:0]            state_q;
	logic [K_BITS-1:0]     cluster_count_q;
	logic [FW-1:0]         fill_q;
	logic [FW-1:0]         j_q;        // hole position during insertion
	logic [FW-1:0]         j_dec;
	logic [SW-1:0]         new_val_q;
	logic [TAG_BITS-1:0]   new_tag_q;
	logic                  last_q;
	logic [FW-1:0]         div_q;      // n / k
	logic [FW-1:0]         pacc_q;     // divisor * (i + 1)
	logic [FW-1:0]         pos;
	logic [CENTER_AW-1:0]  i_q;        // center being picked
	logic [FW-1:0]         m_q;        // sorted item being labeled
	logic [CENTER_AW-1:0]  c_q;        // center read index
	logic                  rd_v_s1;
	logic [CENTER_AW-1:0]  idx_s1;
	logic [SW-1:0]         cur_val_q;
	logic [TAG_BITS-1:0]   cur_tag_q;
	logic                  out_valid_q;
	logic [TAG_BITS-1:0]   out_tag_q;
	logic [SW-1:0]         out_val_q;
	logic [LABEL_BITS-1:0] out_label_q;
	logic                  out_last_q;

	logic [K_BITS-1:0]     k_eff;
	logic [CENTER_AW-1:0]  k_last;
	logic                  in_fire;
	logic                  out_free;

	// sorted ram ports
	logic                  s_we;
	logic [AW-1:0]         s_waddr;
	logic [EW-1:0]         s_wdata;
	logic [AW-1:0]         s_raddr;
	logic [EW-1:0]         s_rdata;
	logic [SW-1:0]         rd_val;
	logic [TAG_BITS-1:0]   rd_tag;

	// center ram ports
	logic                  c_we;
	logic [SW-1:0]         c_rdata;

	// divider
	logic                  div_start;
	logic                  div_done;
	logic [K_BITS-1:0]     div_quo;

	// nearest search
	near_ctl_t             near_ctl;
	logic [LABEL_BITS-1:0] near_label;

	// zero counts as one, anything past the center store saturates
	always_comb begin
		if (cluster_count_q == '0) begin
			k_eff = 7'd1;
		end else if (cluster_count_q > K_MAX) begin
			k_eff = K_MAX;
		end else begin
			k_eff = cluster_count_q;
		end
	end
	assign k_last = CENTER_AW'(k_eff - 7'd1);

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;

	assign rd_val = s_rdata[EW-1:TAG_BITS];
	assign rd_tag = s_rdata[TAG_BITS-1:0];
	assign j_dec  = j_q - 1'b1;
	// center position, clamped to 0 when the divisor is zero
	assign pos    = (pacc_q == '0) ? '0 : pacc_q - 1'b1;

	// sorted ram: write the shifted entry or the new item into the hole
	always_comb begin
		s_we    = 1'b0;
		s_waddr = j_q[AW-1:0];
		s_wdata = {new_val_q, new_tag_q};
		if (state_q == S_INS && j_q == '0) begin
			s_we = 1'b1;
		end else if (state_q == S_CMP) begin
			s_we = 1'b1;
			if (rd_val > new_val_q) begin
				s_wdata = s_rdata;
			end
		end
	end

	always_comb begin
		unique case (state_q)
			S_INS:   s_raddr = j_dec[AW-1:0];
			S_CEN:   s_raddr = pos[AW-1:0];
			S_LRD:   s_raddr = m_q[AW-1:0];
			default: s_raddr = '0;
		endcase
	end

	assign c_we      = (state_q == S_CENW);
	assign div_start = (state_q == S_DIV);

	assign near_ctl.clear = (state_q == S_LCAP);
	assign near_ctl.valid = rd_v_s1;

	qcvc_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_ITEMS)
	) u_sorted_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	qcvc_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_CLUSTERS)
	) u_center_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (i_q),
		.wdata (rd_val),
		.raddr (c_q),
		.rdata (c_rdata)
	);

	qcvc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (K_BITS'(fill_q)),
		.den    (k_eff),
		.done   (div_done),
		.quo    (div_quo)
	);

	qcvc_nearest #(
		.VW (SW)
	) u_nearest (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (near_ctl),
		.value  (cur_val_q),
		.center (c_rdata),
		.index  (idx_s1),
		.label  (near_label)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= K_RESET;
		end else if (cfg_valid && cfg_ready) begin
			cluster_count_q <= cfg_data;
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rd_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == S_SCAN);
			// result register: reload when free, else drop valid once taken
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (fill_q != FW'(MAX_ITEMS)) begin
							state_q <= S_INS;
						end else if (last_item) begin
							// store full: item dropped, the run still closes
							state_q <= S_DIV;
						end
					end
				end
				S_INS: begin
					if (j_q == '0) begin
						fill_q  <= fill_q + 1'b1;
						state_q <= last_q ? S_DIV : S_IDLE;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (rd_val > new_val_q) begin
						state_q <= S_INS;
					end else begin
						fill_q  <= fill_q + 1'b1;
						state_q <= last_q ? S_DIV : S_IDLE;
					end
				end
				S_DIV: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_CEN;
					end
				end
				S_CEN: begin
					state_q <= S_CENW;
				end
				S_CENW: begin
					state_q <= (i_q == k_last) ? S_LRD : S_CEN;
				end
				S_LRD: begin
					state_q <= S_LCAP;
				end
				S_LCAP: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (c_q == k_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						if (m_q == fill_q - 1'b1) begin
							fill_q  <= '0;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_LRD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= c_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					new_val_q <= SW'(item_value);
					new_tag_q <= item_tag;
					last_q    <= last_item;
					j_q       <= fill_q;
				end
			end
			S_CMP: begin
				if (rd_val > new_val_q) begin
					j_q <= j_dec;
				end
			end
			S_DIVW: begin
				if (div_done) begin
					div_q  <= FW'(div_quo);
					pacc_q <= FW'(div_quo);
					i_q    <= '0;
				end
			end
			S_CENW: begin
				i_q    <= i_q + 1'b1;
				pacc_q <= pacc_q + div_q;
				m_q    <= '0;
			end
			S_LCAP: begin
				cur_val_q <= rd_val;
				cur_tag_q <= rd_tag;
				c_q       <= '0;
			end
			S_SCAN: begin
				c_q <= c_q + 1'b1;
			end
			S_EMIT: begin
				if (out_free) begin
					out_tag_q   <= cur_tag_q;
					out_val_q   <= cur_val_q;
					out_label_q <= near_label;
					out_last_q  <= (m_q == fill_q - 1'b1);
					m_q         <= m_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign out_tag       = out_tag_q;
	assign out_value     = OUT_VAL_BITS'(out_val_q);
	assign cluster_label = out_label_q;
	assign last_result   = out_last_q;

endmodule

// ===== design/qcvc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcvc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module qcvc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/qcvc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcvc_div
// iterative divider by repeated subtraction, one subtract per cycle
// ----------------------------------------------------------------------------
module qcvc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [qcvc_pkg::K_BITS-1:0] num,
	input  logic [qcvc_pkg::K_BITS-1:0] den,
	output logic                      done,
	output logic [qcvc_pkg::K_BITS-1:0] quo
);
	import qcvc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [K_BITS-1:0] rem_q;
	logic [K_BITS-1:0] quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && rem_q < den) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			quo_q <= '0;
		end else if (busy_q && rem_q >= den) begin
			rem_q <= rem_q - den;
			quo_q <= quo_q + 1'b1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== design/qcvc_nearest.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcvc_nearest
// running nearest center search, one center compared per cycle
// ----------------------------------------------------------------------------
module qcvc_nearest #(
	parameter int VW = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  qcvc_pkg::near_ctl_t           ctl,
	input  logic [VW-1:0]                 value,
	input  logic [VW-1:0]                 center,
	input  logic [qcvc_pkg::LABEL_BITS-1:0] index,
	output logic [qcvc_pkg::LABEL_BITS-1:0] label
);
	import qcvc_pkg::*;

	logic                  have_q;
	logic [VW-1:0]         best_q;
	logic [LABEL_BITS-1:0] label_q;
	logic [VW-1:0]         span;
	logic                  take;

	assign span = (value >= center) ? value - center : center - value;
	// strict less keeps the lowest index on ties
	assign take = ctl.valid && (!have_q || span < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (ctl.valid) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ctl.clear && take) begin
			best_q  <= span;
			label_q <= index;
		end
	end

	assign label = label_q;

endmodule

// ===== verif/quantile_center_value_clustering_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quantile_center_value_clustering_core_test
// self-checking bench for the quantile center clustering core: data sets of
// tagged values are streamed in, a local model sorts them, picks the centers
// and labels each value, and every result transaction is checked in order
// against the model while both channels idle and stall at random
// ----------------------------------------------------------------------------
module quantile_center_value_clustering_core_test;

	import qcvc_pkg::*;

	localparam int STORE_DEPTH   = 64;
	localparam int SETTLE_CYCLES = 140;  // worst insert time of a full store plus margin
	localparam int DRAIN_CYCLES  = 200;

	// one labeled value as it leaves the core
	typedef struct packed {
		logic [TAG_BITS-1:0]     tag;
		logic [OUT_VAL_BITS-1:0] value;
		logic [LABEL_BITS-1:0]   label;
		logic                    final_flag;
	} labeled_value_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [OUT_VAL_BITS-1:0] item_value = '0;
	logic [TAG_BITS-1:0]     item_tag = '0;
	logic                    last_item = 1'b0;

	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [TAG_BITS-1:0]     out_tag;
	logic [OUT_VAL_BITS-1:0] out_value;
	logic [LABEL_BITS-1:0]   cluster_label;
	logic                    last_result;

	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [K_BITS-1:0]       cfg_data = '0;

	// local copy of the core state
	logic [OUT_VAL_BITS-1:0] held_value [STORE_DEPTH];
	logic [TAG_BITS-1:0]     held_tag [STORE_DEPTH];
	int                      held_count = 0;
	logic [K_BITS-1:0]       cluster_setting = K_RESET;

	labeled_value_t          expected_labels [$];

	int error_count = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int hold_off_cycles = 0;  // long receiver hold-off, counted down by the receiver

	always #10 clk = ~clk;

	quantile_center_value_clustering_core #(
		.MAX_ITEMS (64),
		.VALUE_BITS(16)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.item_value   (item_value),
		.item_tag     (item_tag),
		.last_item    (last_item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_tag      (out_tag),
		.out_value    (out_value),
		.cluster_label(cluster_label),
		.last_result  (last_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// ------------------------------------------------------------------------
	// model: sort the held set stably, pick centers at evenly spaced sorted
	// positions, label each value with the nearest center (lowest index wins)
	// ------------------------------------------------------------------------
	function automatic void label_held_set();
		int                      order [STORE_DEPTH];
		logic [OUT_VAL_BITS-1:0] centers [MAX_CLUSTERS];
		int                      n;
		int                      k;
		int                      divisor;
		int                      pos;
		int                      j;
		int                      best_idx;
		int                      span;
		int                      best_span;
		labeled_value_t          entry;
		n = held_count;
		// insertion sort keeps arrival order among equal values
		for (int i = 0; i < n; i++) begin
			j = i;
			while (j > 0 && held_value[order[j-1]] > held_value[i]) begin
				order[j] = order[j-1];
				j--;
			end
			order[j] = i;
		end
		k = int'(cluster_setting);
		if (k == 0)
			k = 1;           // zero count behaves as one cluster
		if (k > MAX_CLUSTERS)
			k = MAX_CLUSTERS; // counts above the maximum saturate
		divisor = n / k;
		for (int i = 0; i < k; i++) begin
			pos = divisor * (i + 1);
			pos = (pos == 0) ? 0 : pos - 1;  // fewer values than clusters clamps to the first
			if (pos >= n)
				pos = n - 1;
			centers[i] = held_value[order[pos]];
		end
		for (int i = 0; i < n; i++) begin
			best_idx = 0;
			best_span = -1;
			for (int c = 0; c < k; c++) begin
				span = int'(held_value[order[i]]) - int'(centers[c]);
				if (span < 0)
					span = -span;
				if (best_span < 0 || span < best_span) begin
					best_span = span;
					best_idx = c;
				end
			end
			entry.tag = held_tag[order[i]];
			entry.value = held_value[order[i]];
			entry.label = best_idx[LABEL_BITS-1:0];
			entry.final_flag = (i == n - 1);
			expected_labels.insert(expected_labels.size(), entry);
		end
	endfunction

	// accepted item: store it while there is room, a last item closes the set
	function automatic void record_item(logic [OUT_VAL_BITS-1:0] v, logic [TAG_BITS-1:0] t,
			logic closes);
		if (held_count < STORE_DEPTH) begin
			held_value[held_count] = v;
			held_tag[held_count] = t;
			held_count++;
		end
		if (closes && held_count > 0) begin
			label_held_set();
			held_count = 0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// result side: check each transaction, then pick out_ready for the next
	// cycle from the hold-off counter or the stall rate
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		labeled_value_t got;
		labeled_value_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{out_tag, out_value, cluster_label, last_result};
				if (expected_labels.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: unexpected result tag=%0d value=%0d label=%0d last=%0b",
							$realtime, got.tag, got.value, got.label, got.final_flag);
				end else begin
					want = expected_labels.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= 10) begin
							$display("%0t: result mismatch exp tag=%0d value=%0d label=%0d last=%0b",
								$realtime, want.tag, want.value, want.label, want.final_flag);
							$display("%0t: result mismatch act tag=%0d value=%0d label=%0d last=%0b",
								$realtime, got.tag, got.value, got.label, got.final_flag);
						end
					end
				end
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= (int'($urandom_range(99)) >= receiver_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------
	// one item transaction; valid stays high across back-to-back items
	task automatic send_item(input logic [OUT_VAL_BITS-1:0] v, input logic [TAG_BITS-1:0] t,
			input logic closes);
		int gap;
		gap = 0;
		while (sender_idle_pct > 0 && gap < 12 && int'($urandom_range(99)) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		item_value <= v;
		item_tag <= t;
		last_item <= closes;
		do
			@(posedge clk);
		while (!in_ready);
		record_item(v, t, closes);
	endtask

	task automatic go_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_for_results();
		while (expected_labels.size() != 0)
			@(posedge clk);
	endtask

	// cluster count write, only with the core idle
	task automatic write_cluster_count(input logic [K_BITS-1:0] count);
		go_quiet();
		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= count;
		do
			@(posedge clk);
		while (!cfg_ready);
		cluster_setting = count;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_set(input logic [OUT_VAL_BITS-1:0] vals [$],
			input logic [TAG_BITS-1:0] tags [$]);
		for (int i = 0; i < vals.size(); i++)
			send_item(vals[i], tags[i], i == vals.size() - 1);
	endtask

	// random set of the given size; narrow value ranges give many ties
	task automatic send_random_set(input int n);
		int mode;
		logic [OUT_VAL_BITS-1:0] v;
		mode = $urandom_range(2);
		for (int i = 0; i < n; i++) begin
			case (mode)
				0: v = OUT_VAL_BITS'($urandom_range(16'hFFFF));
				1: v = OUT_VAL_BITS'($urandom_range(7));
				default: v = 16'h7FF0 + OUT_VAL_BITS'($urandom_range(31));
			endcase
			send_item(v, TAG_BITS'($urandom_range(63)), i == n - 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	// reset count of 20 with fewer values than clusters: every center is the
	// smallest value, field extremes and equal values in arrival order
	task automatic test_reset_count();
		send_set('{16'hFFFF, 16'h0000, 16'd100, 16'd100, 16'h8000},
			'{6'd63, 6'd0, 6'd21, 6'd42, 6'd5});
	endtask

	task automatic test_single_cluster();
		write_cluster_count(7'd1);
		send_set('{16'd9, 16'd3, 16'hFFFE, 16'd3}, '{6'd1, 6'd2, 6'd3, 6'd4});
	endtask

	// a zero count labels like a single cluster
	task automatic test_zero_count();
		write_cluster_count(7'd0);
		send_set('{16'd500, 16'd1, 16'd250}, '{6'd10, 6'd11, 6'd12});
	endtask

	// all-ones count saturates to the cluster maximum
	task automatic test_saturated_count();
		write_cluster_count(7'h7F);
		send_set('{16'h5555, 16'hAAAA, 16'd0, 16'd1, 16'hFFFF, 16'd2},
			'{6'h15, 6'h2A, 6'd7, 6'd8, 6'd9, 6'h3F});
	endtask

	// equal distance to two centers goes to the lower index; one-item set too
	task automatic test_distance_ties();
		write_cluster_count(7'd2);
		send_set('{16'd40, 16'd10, 16'd30, 16'd20}, '{6'd0, 6'd1, 6'd2, 6'd3});
		send_set('{16'd1234}, '{6'd33});
	endtask

	// 64 values fill the store, the next item and the closing item are dropped
	task automatic test_full_store();
		write_cluster_count(K_MAX);
		sender_idle_pct = 0;
		receiver_stall_pct = 49;
		for (int i = 0; i < STORE_DEPTH; i++)
			send_item(OUT_VAL_BITS'($urandom_range(16'hFFFF)), i[TAG_BITS-1:0], 1'b0);
		send_item(16'hFFFF, 6'd63, 1'b0);
		send_item(16'd0, 6'd0, 1'b1);
	endtask

	// receiver holds off long while three sets are sent, stalling the core and
	// the sender behind it, then the sender pauses until every result is back
	task automatic test_backpressure();
		write_cluster_count(7'd3);
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		hold_off_cycles = 800;
		repeat (3) send_random_set(8);
		go_quiet();
		wait_for_results();
	endtask

	task automatic test_random_sets(input int items, input int idle_pct, input int stall_pct);
		int sent;
		int n;
		int pick;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(1) == 1) begin
				pick = $urandom_range(9);
				case (pick)
					0: write_cluster_count(7'd1);
					1: write_cluster_count(K_MAX);
					2: write_cluster_count(K_BITS'($urandom_range(127, 65)));
					3: write_cluster_count(7'd0);
					4: write_cluster_count(K_BITS'($urandom_range(63, 13)));
					default: write_cluster_count(K_BITS'($urandom_range(12, 2)));
				endcase
			end
			n = ($urandom_range(9) == 0) ? $urandom_range(30, 11) : $urandom_range(10, 1);
			send_random_set(n);
			sent += n;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_count();
		test_single_cluster();
		test_zero_count();
		test_saturated_count();
		test_distance_ties();
		test_full_store();
		test_backpressure();
		test_random_sets(22, 0, 0);
		test_random_sets(22, 49, 0);
		test_random_sets(22, 0, 49);
		test_random_sets(22, 9, 9);

		go_quiet();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && expected_labels.size() == 0) begin
			$display("quantile_center_value_clustering_core_test: clean");
		end else begin
			$display("quantile_center_value_clustering_core_test: errors");
		end
		$finish;
	end

	// a hung handshake ends the run
	initial begin
		#200_000_000;
		$display("quantile_center_value_clustering_core_test: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/qcvc_pkg.sv
design/qcvc_ram.sv
design/qcvc_div.sv
design/qcvc_nearest.sv
design/quantile_center_value_clustering_core.sv
verif/quantile_center_value_clustering_core_test.sv
